@@ sv/gccp_pkg.sv @@
package gccp_pkg;

	typedef enum logic [1:0] {
		OP_ACQUIRE = 2'd0,
		OP_FINISH  = 2'd1,
		OP_QUERY   = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_POOL_EMPTY = 2'd1,
		ST_ZERO_COUNT = 2'd2
	} status_t;

	typedef struct packed {
		op_t         operation;
		logic [15:0] initial_count;
		logic [7:0]  slot_index;
		logic [15:0] handle_generation;
		logic        handle_valid;
	} request_t;

	typedef struct packed {
		logic [7:0]  result_slot;
		logic [15:0] result_generation;
		logic        completed;
		logic        reached_zero;
		status_t     status;
	} result_t;

	// Decisions made when a transaction is accepted, carried down the pipeline.
	typedef struct packed {
		logic acq_ok;
		logic usable;
		logic in_range;
	} slot_flags_t;

endpackage

@@ sv/gccp_slot_ram.sv @@
module gccp_slot_ram #(
	parameter int DEPTH  = 256,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// A write landing in the same cycle as the read is forwarded, so the
	// following transaction sees the value just computed.
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/gccp_free_stack.sv @@
module gccp_free_stack #(
	parameter int SLOT_COUNT = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clear,
	input  logic [$clog2(SLOT_COUNT)-1:0]   clear_addr,
	input  logic                            acquire,
	input  logic                            release_slot,
	input  logic [$clog2(SLOT_COUNT)-1:0]   push_slot,
	output logic                            empty,
	output logic [$clog2(SLOT_COUNT)-1:0]   pop_slot
);

	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int TOP_W  = $clog2(SLOT_COUNT + 1);

	logic [SLOT_W-1:0] mem [SLOT_COUNT];
	logic [TOP_W-1:0]  top_q;
	logic [TOP_W-1:0]  top_m1;
	logic [SLOT_W-1:0] pop_slot_q;
	logic              pop;
	logic              push;

	assign empty  = (top_q == '0);
	assign top_m1 = top_q - 1'b1;
	assign pop    = acquire && !empty;
	// A release onto a full stack still bumps the generation; only the push is dropped.
	assign push   = release_slot && (top_q != TOP_W'(SLOT_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= TOP_W'(SLOT_COUNT);
		end else if (pop) begin
			top_q <= top_m1;
		end else if (push) begin
			top_q <= top_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			mem[clear_addr] <= clear_addr;
		end else if (push) begin
			mem[top_q[SLOT_W-1:0]] <= push_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pop_slot_q <= mem[top_m1[SLOT_W-1:0]];
		end
	end

	assign pop_slot = pop_slot_q;

`ifndef SYNTH
	a_top_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TOP_W'(SLOT_COUNT))
		else $error("free stack pointer beyond pool size");
`endif

endmodule

@@ sv/gccp_exec.sv @@
module gccp_exec #(
	parameter int SLOT_W          = 8,
	parameter int GENERATION_BITS = 16,
	parameter int COUNT_BITS      = 16
) (
	input  gccp_pkg::request_t           req,
	input  gccp_pkg::slot_flags_t        flags,
	input  logic [SLOT_W-1:0]            slot,
	input  logic [COUNT_BITS-1:0]        cnt_rd,
	input  logic [GENERATION_BITS-1:0]   gen_rd,
	output logic                         cnt_we,
	output logic [COUNT_BITS-1:0]        cnt_wd,
	output logic                         gen_we,
	output logic [GENERATION_BITS-1:0]   gen_wd,
	output gccp_pkg::result_t            res
);

	import gccp_pkg::*;

	logic [GENERATION_BITS-1:0] gen_inc;
	logic [GENERATION_BITS-1:0] gen_out;

	assign gen_inc = GENERATION_BITS'(gen_rd + 1'b1);
	assign gen_wd  = gen_inc;

	always_comb begin
		cnt_we               = 1'b0;
		cnt_wd               = COUNT_BITS'(32'(req.initial_count));
		gen_we               = 1'b0;
		gen_out              = flags.in_range ? gen_rd : '0;
		res.result_slot      = req.slot_index;
		res.completed        = 1'b0;
		res.reached_zero     = 1'b0;
		res.status           = ST_OK;
		unique case (req.operation)
			OP_ACQUIRE: begin
				if (flags.acq_ok) begin
					cnt_we          = 1'b1;
					res.result_slot = 8'(32'(slot));
					gen_out         = gen_rd;
				end else begin
					res.result_slot = '0;
					res.status      = ST_POOL_EMPTY;
					gen_out         = '0;
				end
			end
			OP_FINISH: begin
				if (flags.usable) begin
					if (cnt_rd == '0) begin
						res.status = ST_ZERO_COUNT;
					end else begin
						cnt_we           = 1'b1;
						cnt_wd           = COUNT_BITS'(cnt_rd - 1'b1);
						res.reached_zero = (cnt_rd == COUNT_BITS'(1));
					end
				end
			end
			OP_QUERY: begin
				res.completed = !flags.usable
					|| (gen_rd != GENERATION_BITS'(32'(req.handle_generation)))
					|| (cnt_rd == '0);
			end
			OP_RELEASE: begin
				if (flags.usable) begin
					gen_we  = 1'b1;
					gen_out = gen_inc;
				end
			end
		endcase
		res.result_generation = 16'(32'(gen_out));
	end

endmodule

@@ sv/generational_completion_counter_pool_top.sv @@
// An accepted transaction passes stage 1 and stage 2 before its result is
// strobed; one transaction can be accepted every cycle while busy is low.
// The pending-count and generation memories are read one stage after accept
// and written back in the next, with same-cycle forwarding between them.
// After reset, busy stays high while the memories are cleared and the free
// stack is loaded; the receiver cannot stall results.
module generational_completion_counter_pool_top #(
	parameter int SLOT_COUNT      = 256,
	parameter int GENERATION_BITS = 16,
	parameter int COUNT_BITS      = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  gccp_pkg::request_t  request,
	output logic                strobe,
	output gccp_pkg::result_t   result
);

	import gccp_pkg::*;

	localparam int SLOT_W = $clog2(SLOT_COUNT);

	logic                       clear_q;
	logic [SLOT_W-1:0]          clr_addr_q;
	logic                       accept;
	logic                       in_range;
	logic                       usable;
	logic                       empty;
	logic [SLOT_W-1:0]          req_slot;
	logic [SLOT_W-1:0]          pop_slot;

	logic                       valid_s1;
	request_t                   req_s1;
	slot_flags_t                flags_s1;
	logic [SLOT_W-1:0]          addr_s1;

	logic                       valid_s2;
	request_t                   req_s2;
	slot_flags_t                flags_s2;
	logic [SLOT_W-1:0]          addr_s2;

	logic [COUNT_BITS-1:0]      cnt_rd;
	logic [GENERATION_BITS-1:0] gen_rd;
	logic                       cnt_we;
	logic [COUNT_BITS-1:0]      cnt_wd;
	logic                       gen_we;
	logic [GENERATION_BITS-1:0] gen_wd;
	result_t                    res;

	logic                       cnt_wen;
	logic [SLOT_W-1:0]          cnt_waddr;
	logic [COUNT_BITS-1:0]      cnt_wdata;
	logic                       gen_wen;
	logic [SLOT_W-1:0]          gen_waddr;
	logic [GENERATION_BITS-1:0] gen_wdata;

	logic                       strobe_q;
	result_t                    result_q;

	assign busy     = clear_q;
	assign accept   = start && !busy;
	assign in_range = (32'(request.slot_index) < SLOT_COUNT);
	assign usable   = request.handle_valid && in_range;
	assign req_slot = SLOT_W'(32'(request.slot_index));

	// Clearing pass: one entry of every memory per cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			if (clr_addr_q == SLOT_W'(SLOT_COUNT - 1)) begin
				clear_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	gccp_free_stack #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_free_stack (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (clear_q),
		.clear_addr  (clr_addr_q),
		.acquire     (accept && (request.operation == OP_ACQUIRE)),
		.release_slot(accept && (request.operation == OP_RELEASE) && usable),
		.push_slot   (req_slot),
		.empty       (empty),
		.pop_slot    (pop_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			strobe_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		req_s1            <= request;
		flags_s1.acq_ok   <= !empty;
		flags_s1.usable   <= usable;
		flags_s1.in_range <= in_range;
		req_s2            <= req_s1;
		flags_s2          <= flags_s1;
		addr_s2           <= addr_s1;
		result_q          <= res;
	end

	// An acquire learns its slot from the free stack read registered at accept.
	assign addr_s1 = (req_s1.operation == OP_ACQUIRE) ? pop_slot
		: SLOT_W'(32'(req_s1.slot_index));

	assign cnt_wen   = clear_q || (valid_s2 && cnt_we);
	assign cnt_waddr = clear_q ? clr_addr_q : addr_s2;
	assign cnt_wdata = clear_q ? '0 : cnt_wd;
	assign gen_wen   = clear_q || (valid_s2 && gen_we);
	assign gen_waddr = clear_q ? clr_addr_q : addr_s2;
	assign gen_wdata = clear_q ? '0 : gen_wd;

	gccp_slot_ram #(
		.DEPTH (SLOT_COUNT),
		.WIDTH (COUNT_BITS),
		.ADDR_W(SLOT_W)
	) u_count_ram (
		.clk  (clk),
		.we   (cnt_wen),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(addr_s1),
		.rdata(cnt_rd)
	);

	gccp_slot_ram #(
		.DEPTH (SLOT_COUNT),
		.WIDTH (GENERATION_BITS),
		.ADDR_W(SLOT_W)
	) u_gen_ram (
		.clk  (clk),
		.we   (gen_wen),
		.waddr(gen_waddr),
		.wdata(gen_wdata),
		.raddr(addr_s1),
		.rdata(gen_rd)
	);

	gccp_exec #(
		.SLOT_W         (SLOT_W),
		.GENERATION_BITS(GENERATION_BITS),
		.COUNT_BITS     (COUNT_BITS)
	) u_exec (
		.req   (req_s2),
		.flags (flags_s2),
		.slot  (addr_s2),
		.cnt_rd(cnt_rd),
		.gen_rd(gen_rd),
		.cnt_we(cnt_we),
		.cnt_wd(cnt_wd),
		.gen_we(gen_we),
		.gen_wd(gen_wd),
		.res   (res)
	);

	assign strobe = strobe_q;
	assign result = result_q;

`ifndef SYNTH
	a_idle_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (!valid_s1 && !valid_s2 && !strobe))
		else $error("transaction in flight during clearing pass");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 strobe)
		else $error("accepted transaction produced no result");

	a_zero_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.reached_zero) |-> (result.status == ST_OK))
		else $error("reached zero reported together with an error status");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import gccp_pkg::*;

	typedef struct packed {
		logic [7:0]  slot;
		logic [15:0] gen;
	} handle_t;

	typedef struct packed {
		request_t req;
		bit       drain_first;
		bit       calm;
	} pending_op_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	request_t request = '0;
	logic     strobe;
	result_t  result;

	generational_completion_counter_pool_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.strobe(strobe),
		.result(result)
	);

	always #1 clk = ~clk;

	// Two copies of the pool: index 0 plans the stimulus ahead of time,
	// index 1 follows the accepted transactions and predicts results.
	localparam int PLAN = 0;
	localparam int TRACK = 1;

	logic [7:0]  free_slots [2][256];
	int          free_top [2];
	logic [15:0] jobs_left [2][256];
	logic [15:0] slot_gen [2][256];

	pending_op_t ops_q[$];
	result_t     pool_answers_q[$];
	handle_t     live_q[$];
	int          idle_left = 0;
	int          errors = 0;

	function automatic void pool_clear(input int m);
		for (int i = 0; i < 256; i++) begin
			free_slots[m][i] = 8'(i);
			jobs_left[m][i] = '0;
			slot_gen[m][i] = '0;
		end
		free_top[m] = 256;
	endfunction

	function automatic result_t pool_step(input int m, input request_t r);
		result_t    y;
		logic [7:0] s;
		y = '0;
		y.result_slot = r.slot_index;
		y.status = ST_OK;
		s = r.slot_index;
		case (r.operation)
			OP_ACQUIRE: begin
				if (free_top[m] == 0) begin
					y.result_slot = '0;
					y.status = ST_POOL_EMPTY;
				end else begin
					free_top[m]--;
					s = free_slots[m][free_top[m]];
					jobs_left[m][s] = r.initial_count;
					y.result_slot = s;
					y.result_generation = slot_gen[m][s];
				end
			end
			OP_FINISH: begin
				if (r.handle_valid) begin
					if (jobs_left[m][s] == '0) begin
						y.status = ST_ZERO_COUNT;
					end else begin
						y.reached_zero = (jobs_left[m][s] == 16'd1);
						jobs_left[m][s] = jobs_left[m][s] - 16'd1;
					end
				end
				y.result_generation = slot_gen[m][s];
			end
			OP_QUERY: begin
				y.completed = !r.handle_valid || slot_gen[m][s] != r.handle_generation
					|| jobs_left[m][s] == '0;
				y.result_generation = slot_gen[m][s];
			end
			OP_RELEASE: begin
				if (r.handle_valid) begin
					slot_gen[m][s] = slot_gen[m][s] + 16'd1;
					// A push onto a full stack is dropped.
					if (free_top[m] < 256) begin
						free_slots[m][free_top[m]] = s;
						free_top[m]++;
					end
				end
				y.result_generation = slot_gen[m][s];
			end
			default: y = '0;
		endcase
		return y;
	endfunction

	function automatic request_t req_of(input op_t op, input logic [15:0] cnt,
			input logic [7:0] slot, input logic [15:0] gen, input logic valid);
		request_t r;
		r.operation = op;
		r.initial_count = cnt;
		r.slot_index = slot;
		r.handle_generation = gen;
		r.handle_valid = valid;
		return r;
	endfunction

	function automatic void plan(input request_t r, input bit drain_first = 1'b0,
			input bit calm = 1'b0);
		result_t     y;
		pending_op_t p;
		handle_t     h;
		p.req = r;
		p.drain_first = drain_first;
		p.calm = calm;
		ops_q = {ops_q, p};
		y = pool_step(PLAN, r);
		if (r.operation == OP_ACQUIRE && y.status == ST_OK) begin
			h.slot = y.result_slot;
			h.gen = y.result_generation;
			live_q = {live_q, h};
		end
	endfunction

	function automatic void flag_field(input string field, input int unsigned want,
			input int unsigned got);
		errors++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endfunction

	// Driver: presents the oldest pending transaction and predicts it once accepted.
	always @(posedge clk or negedge arst_n) begin
		bit      go;
		result_t y;
		go = 1'b0;
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
			idle_left = 0;
		end else begin
			if (start && !busy) begin
				y = pool_step(TRACK, request);
				pool_answers_q = {pool_answers_q, y};
				if (!ops_q[0].calm && $urandom_range(0, 9) == 0)
					idle_left = $urandom_range(1, 12);
				void'(ops_q.pop_front());
			end
			if (start && busy) begin
				go = 1'b1;
			end else if (idle_left > 0) begin
				idle_left--;
			end else if (ops_q.size() != 0) begin
				go = !(ops_q[0].drain_first && pool_answers_q.size() != 0);
			end
			start <= go;
			if (go)
				request <= ops_q[0].req;
		end
	end

	// Monitor: every strobed result is checked against the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe === 1'b1) begin
			if (pool_answers_q.size() == 0) begin
				flag_field("unexpected result_slot", 0, result.result_slot);
			end else begin
				want = pool_answers_q.pop_front();
				if (result.result_slot !== want.result_slot)
					flag_field("result_slot", want.result_slot, result.result_slot);
				if (result.result_generation !== want.result_generation)
					flag_field("result_generation", want.result_generation,
						result.result_generation);
				if (result.completed !== want.completed)
					flag_field("completed", want.completed, result.completed);
				if (result.reached_zero !== want.reached_zero)
					flag_field("reached_zero", want.reached_zero, result.reached_zero);
				if (result.status !== want.status)
					flag_field("status", want.status, result.status);
			end
		end
	end

	initial begin
		#2000000;
		$display("generational_completion_counter_pool_top regression: fail");
		$finish;
	end

	initial begin
		logic [7:0] order [256];
		logic [7:0] tmp;
		handle_t    h;
		int         j;
		int         k;
		int         pick;
		bit         calm;
		pool_clear(PLAN);
		pool_clear(TRACK);

		// Directed: count at zero, invalid handles, stale generations, full stack.
		plan(req_of(OP_QUERY, 16'd0, 8'd0, 16'd0, 1'b1));
		plan(req_of(OP_FINISH, 16'd0, 8'd0, 16'd0, 1'b1));
		plan(req_of(OP_FINISH, 16'd0, 8'd0, 16'd0, 1'b0));
		plan(req_of(OP_RELEASE, 16'd0, 8'd3, 16'd0, 1'b1));
		plan(req_of(OP_ACQUIRE, 16'd1, 8'd0, 16'd0, 1'b0));
		plan(req_of(OP_QUERY, 16'd0, 8'd255, 16'd0, 1'b1));
		plan(req_of(OP_QUERY, 16'd0, 8'd255, 16'hFFFF, 1'b1));
		plan(req_of(OP_QUERY, 16'd0, 8'd255, 16'd0, 1'b0));
		plan(req_of(OP_FINISH, 16'd0, 8'd255, 16'd0, 1'b0));
		plan(req_of(OP_FINISH, 16'd0, 8'd255, 16'd0, 1'b1));
		plan(req_of(OP_FINISH, 16'd0, 8'd255, 16'd0, 1'b1));
		plan(req_of(OP_ACQUIRE, 16'hFFFF, 8'd0, 16'd0, 1'b1));
		plan(req_of(OP_FINISH, 16'd0, 8'd254, 16'd0, 1'b1));
		plan(req_of(OP_QUERY, 16'd0, 8'd254, 16'd0, 1'b1));
		plan(req_of(OP_ACQUIRE, 16'd0, 8'd0, 16'd0, 1'b1));
		plan(req_of(OP_QUERY, 16'd0, 8'd253, 16'd0, 1'b1));
		plan(req_of(OP_RELEASE, 16'd0, 8'd255, 16'd0, 1'b0));
		plan(req_of(OP_RELEASE, 16'd0, 8'd255, 16'd0, 1'b1));
		plan(req_of(OP_ACQUIRE, 16'd2, 8'd0, 16'd0, 1'b1));
		plan(req_of(OP_QUERY, 16'd0, 8'd255, 16'd0, 1'b1));
		plan(req_of(OP_QUERY, 16'd0, 8'd255, 16'd1, 1'b1));
		plan(req_of(OP_RELEASE, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1));
		plan(req_of(OP_FINISH, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1));

		// Drain the pool past empty, then hand every slot back in random order.
		for (int i = 0; i < 260; i++)
			plan(req_of(OP_ACQUIRE, 16'($urandom_range(1, 3)), 8'($urandom),
				16'($urandom), 1'($urandom)), i == 0);
		for (int i = 0; i < 256; i++)
			order[i] = 8'(i);
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < 259; i++)
			plan(req_of(OP_RELEASE, 16'($urandom), order[i % 256], 16'($urandom), 1'b1));
		live_q.delete();

		// Release one slot a few more times; every push is dropped because the
		// stack is full.
		for (int i = 0; i < 4; i++)
			plan(req_of(OP_RELEASE, 16'd0, 8'd7, 16'd0, 1'b1), i == 0, 1'b1);
		plan(req_of(OP_QUERY, 16'd0, 8'd7, slot_gen[PLAN][7], 1'b1));

		// Random handle lifecycles with some noise mixed in.
		for (int i = 0; i < 300; i++) begin
			calm = (i >= 240);
			pick = $urandom_range(0, 99);
			k = (live_q.size() != 0) ? $urandom_range(0, live_q.size() - 1) : 0;
			if (live_q.size() != 0)
				h = live_q[k];
			if (pick < 22 && live_q.size() < 40) begin
				plan(req_of(OP_ACQUIRE, ($urandom_range(0, 9) == 0) ? 16'($urandom) :
					16'($urandom_range(1, 4)), 8'($urandom), 16'($urandom), 1'($urandom)),
					!calm && $urandom_range(0, 99) == 0, calm);
			end else if (pick < 52 && live_q.size() != 0) begin
				plan(req_of(OP_FINISH, 16'($urandom), h.slot, 16'($urandom),
					$urandom_range(0, 19) != 0), 1'b0, calm);
			end else if (pick < 72 && live_q.size() != 0) begin
				plan(req_of(OP_QUERY, 16'($urandom), h.slot,
					($urandom_range(0, 4) == 0) ? h.gen + 16'd1 : h.gen,
					$urandom_range(0, 19) != 0), 1'b0, calm);
			end else if (pick < 84 && live_q.size() != 0) begin
				live_q.delete(k);
				plan(req_of(OP_RELEASE, 16'($urandom), h.slot, h.gen, 1'b1),
					!calm && $urandom_range(0, 19) == 0, calm);
			end else begin
				plan(req_of(op_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
					16'($urandom), 1'($urandom)), 1'b0, calm);
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (ops_q.size() != 0 || pool_answers_q.size() != 0);
		repeat (8) @(negedge clk);

		if (errors == 0 && pool_answers_q.size() == 0)
			$display("generational_completion_counter_pool_top regression: pass");
		else
			$display("generational_completion_counter_pool_top regression: fail");
		$finish;
	end

endmodule
